[hdl/pfa_pkg.sv]
// shared types and constants for the page frame allocator
// no dependencies; imported by pfa_stack_mem and page_frame_allocator
package pfa_pkg;

    localparam int PFA_STACK_DEPTH = 1024;
    localparam int PFA_FRAME_BYTES = 4096;
    localparam int PFA_ADDR_W      = 32;
    localparam int PFA_PAGE_SHIFT  = $clog2(PFA_FRAME_BYTES);
    localparam int PFA_PAGE_W      = PFA_ADDR_W - PFA_PAGE_SHIFT;
    localparam int PFA_COUNT_W     = 11;
    localparam int PFA_CFG_IDX_W   = 8;

    // configuration register indexes
    localparam logic [PFA_CFG_IDX_W-1:0] CFG_REGION_START = PFA_CFG_IDX_W'(0);
    localparam logic [PFA_CFG_IDX_W-1:0] CFG_PAGING_ON    = PFA_CFG_IDX_W'(1);

    // request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_IGNORED = 2'd2,
        STAT_FULL    = 2'd3
    } pfa_status_t;

    typedef struct packed {
        logic                  action;
        logic [PFA_ADDR_W-1:0] frame_address;
    } pfa_req_t;

    typedef struct packed {
        logic [PFA_ADDR_W-1:0]  granted_address;
        pfa_status_t            status;
        logic [PFA_COUNT_W-1:0] free_count;
    } pfa_rsp_t;

endpackage

[hdl/page_frame_allocator.sv]
// page frame allocator top level: bump allocation and a lifo free stack in memory
// depends on pfa_pkg and pfa_stack_mem
// timing: the result strobe comes in the cycle after the execute cycle; busy holds off a
//   new request until the execute cycle ends; the free stack memory is read while the
//   request is accepted, ahead of the update
// reset: asynchronous active low; bump page set to 1, count and mode clear, stack contents stay
// the receiver cannot stall: each result shows for exactly one cycle on done
module page_frame_allocator #(
    parameter int STACK_DEPTH = pfa_pkg::PFA_STACK_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  pfa_pkg::pfa_req_t                 req,
    // result channel
    output logic                              done,
    output pfa_pkg::pfa_rsp_t                 rsp,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfa_pkg::PFA_CFG_IDX_W-1:0] cfg_index,
    input  logic [pfa_pkg::PFA_ADDR_W-1:0]    cfg_data
);
    import pfa_pkg::*;

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int TOP_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                state_reg, state_next;

    // request captured at the accepting edge
    pfa_req_t              req_reg;

    // mode and bump end, kept as a page number: base page plus frames handed out
    logic                  paging_reg;
    logic [PFA_PAGE_W-1:0] bump_page_reg, bump_page_next;

    // number of entries on the free stack
    logic [TOP_W-1:0]      stack_top_reg, stack_top_next;
    logic [TOP_W-1:0]      top_dec;

    // result register
    logic                  done_reg;
    pfa_rsp_t              rsp_reg, rsp_next;

    // memory port
    logic                  mem_rd_en;
    logic                  mem_wr_en;
    logic [PFA_ADDR_W-1:0] mem_rd_data;

    logic                  accept;
    logic                  cfg_write;
    logic                  stack_full;
    logic                  free_low;

    // count after the step, masked to the result width
    function automatic logic [PFA_COUNT_W-1:0] top_ext_next(input logic [TOP_W-1:0] top);
        logic [TOP_W+PFA_COUNT_W-1:0] ext;
        ext = {{PFA_COUNT_W{1'b0}}, top};
        return ext[PFA_COUNT_W-1:0];
    endfunction

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    // config only lands while idle
    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_write = cfg_valid && cfg_ready;

    assign top_dec    = stack_top_reg - TOP_W'(1);
    assign stack_full = (stack_top_reg == TOP_W'(STACK_DEPTH));

    // free address below bump end plus one page: page number compare suffices,
    // since the limit is page aligned and its page may carry into bit 32
    assign free_low = (req_reg.frame_address[PFA_ADDR_W-1:PFA_PAGE_SHIFT] <= bump_page_reg);

    // pop reads the top entry while the request is accepted; the count only
    // moves at the end of the execute cycle, so no forwarding is needed
    assign mem_rd_en = accept && (req.action == ACT_ALLOC);

    always_comb
    begin
        state_next     = state_reg;
        bump_page_next = bump_page_reg;
        stack_top_next = stack_top_reg;
        mem_wr_en      = 1'b0;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
                // rewriting the region start restarts the bump pointer
                if (cfg_write && (cfg_index == CFG_REGION_START))
                begin
                    bump_page_next = cfg_data[PFA_ADDR_W-1:PFA_PAGE_SHIFT] + PFA_PAGE_W'(1);
                end
            end
            S_EXEC:
            begin
                state_next               = S_IDLE;
                rsp_next.granted_address = '0;
                rsp_next.status          = STAT_OK;
                if (req_reg.action == ACT_ALLOC)
                begin
                    if (!paging_reg)
                    begin
                        rsp_next.granted_address = {bump_page_reg, {PFA_PAGE_SHIFT{1'b0}}};
                        bump_page_next           = bump_page_reg + PFA_PAGE_W'(1);
                    end
                    else if (stack_top_reg == '0)
                    begin
                        rsp_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        rsp_next.granted_address = mem_rd_data;
                        stack_top_next           = top_dec;
                    end
                end
                else
                begin
                    if (!paging_reg || free_low)
                    begin
                        rsp_next.status = STAT_IGNORED;
                    end
                    else if (stack_full)
                    begin
                        rsp_next.status = STAT_FULL;
                    end
                    else
                    begin
                        mem_wr_en      = 1'b1;
                        stack_top_next = stack_top_reg + TOP_W'(1);
                    end
                end
                rsp_next.free_count = top_ext_next(stack_top_next);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            paging_reg    <= 1'b0;
            bump_page_reg <= PFA_PAGE_W'(1);
            stack_top_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bump_page_reg <= bump_page_next;
            stack_top_reg <= stack_top_next;
            done_reg      <= (state_reg == S_EXEC);
            if (cfg_write && (cfg_index == CFG_PAGING_ON))
            begin
                paging_reg <= cfg_data[0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    pfa_stack_mem #(
        .DEPTH (STACK_DEPTH)
    ) u_stack_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (stack_top_reg[IDX_W-1:0]),
        .wr_data (req_reg.frame_address),
        .rd_en   (mem_rd_en),
        .rd_addr (top_dec[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // a result strobe only follows an execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without an execute cycle");

    // the stack count never passes the depth
    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stack_top_reg <= TOP_W'(STACK_DEPTH))
        else $error("free stack count beyond depth");

    // any transaction that is not a grant carries a zero address
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != STAT_OK) |-> (rsp.granted_address == '0))
        else $error("nonzero address on a failed transaction");

    // the count moves by at most one, and only at the end of an execute cycle
    a_top_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stack_top_reg) |-> $past(state_reg == S_EXEC) && done)
        else $error("stack count moved outside an execute cycle");

endmodule

[hdl/pfa_stack_mem.sv]
// free stack storage: one write port, one read port, registered read data
// depends on pfa_pkg for the address width
module pfa_stack_mem #(
    parameter int DEPTH = pfa_pkg::PFA_STACK_DEPTH
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [pfa_pkg::PFA_ADDR_W-1:0] wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [pfa_pkg::PFA_ADDR_W-1:0] rd_data
);
    import pfa_pkg::*;

    logic [PFA_ADDR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[tb/page_frame_allocator_tb.sv]
// self-checking testbench for page_frame_allocator: directed table, then random phases
// depends on pfa_pkg and the page_frame_allocator rtl; expected results are typed into
// the table or come from a bench copy of the bump pointer, free stack and registers
module page_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    // register indexes past the last real one, writes there must be dropped
    localparam logic [PFA_CFG_IDX_W-1:0] CFG_SPARE_LOW = CFG_PAGING_ON + 1'b1;
    localparam logic [PFA_CFG_IDX_W-1:0] CFG_SPARE_TOP = '1;

    logic clk = 1'b0;
    logic rst_n;

    // request channel
    logic     start;
    logic     busy;
    pfa_req_t req;

    // result channel, one strobe per result, no back-pressure
    logic     done;
    pfa_rsp_t rsp;

    // configuration write channel
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [PFA_CFG_IDX_W-1:0] cfg_index;
    logic [PFA_ADDR_W-1:0]    cfg_data;

    page_frame_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow copy of the allocator state, updated per accepted transaction
    logic [PFA_ADDR_W-1:0] exp_region;
    logic                  exp_paging;
    logic [19:0]           exp_bump;
    logic [PFA_ADDR_W-1:0] exp_stack [PFA_STACK_DEPTH];
    int                    exp_depth;

    // results still owed by the dut, oldest first
    pfa_rsp_t owed_grants[$];
    int       mismatches = 0;
    pfa_rsp_t want;

    // one row of the directed table: either a register write or a request,
    // with a hand-typed result where it is obvious
    typedef struct packed {
        bit                       is_cfg;
        logic [PFA_CFG_IDX_W-1:0] idx;
        logic [PFA_ADDR_W-1:0]    data;
        pfa_req_t                 op;
        bit                       typed;
        pfa_rsp_t                 want;
    } script_row_t;

    script_row_t script[$];

    // next bump address: page-aligned base past region_start plus allocated frames
    function automatic logic [PFA_ADDR_W-1:0] bump_frontier();
        logic [PFA_ADDR_W-1:0] base;
        base = (exp_region + PFA_ADDR_W'(PFA_FRAME_BYTES)) & ~PFA_ADDR_W'(PFA_FRAME_BYTES - 1);
        return base + PFA_ADDR_W'(exp_bump) * PFA_ADDR_W'(PFA_FRAME_BYTES);
    endfunction

    function automatic void apply_reg(logic [PFA_CFG_IDX_W-1:0] idx, logic [PFA_ADDR_W-1:0] data);
        if (idx == CFG_REGION_START)
        begin
            // new base restarts bump allocation
            exp_region = data;
            exp_bump   = '0;
        end
        else if (idx == CFG_PAGING_ON)
        begin
            exp_paging = data[0];
        end
    endfunction

    // expected result of one request, advancing the shadow state
    function automatic pfa_rsp_t predict_frame_op(pfa_req_t op);
        pfa_rsp_t            r;
        logic [PFA_ADDR_W:0] floor_addr;
        logic [PFA_ADDR_W:0] page_span;
        r.granted_address = '0;
        r.status          = STAT_OK;
        page_span         = (PFA_ADDR_W+1)'(PFA_FRAME_BYTES);
        if (op.action == ACT_ALLOC)
        begin
            if (!exp_paging)
            begin
                r.granted_address = bump_frontier();
                exp_bump          = exp_bump + 1'b1;
            end
            else if (exp_depth == 0)
            begin
                r.status = STAT_EMPTY;
            end
            else
            begin
                exp_depth         = exp_depth - 1;
                r.granted_address = exp_stack[exp_depth];
            end
        end
        else
        begin
            // 33-bit compare so a frontier near the top ignores every free
            floor_addr = {1'b0, bump_frontier()} + page_span;
            if (!exp_paging || {1'b0, op.frame_address} < floor_addr)
                r.status = STAT_IGNORED;
            else if (exp_depth >= PFA_STACK_DEPTH)
                r.status = STAT_FULL;
            else
            begin
                exp_stack[exp_depth] = op.frame_address;
                exp_depth            = exp_depth + 1;
            end
        end
        r.free_count = PFA_COUNT_W'(exp_depth);
        return r;
    endfunction

    // address for a free: mostly at or above the bump frontier plus one page, so it
    // lands on the stack, some just below that bound, some anywhere
    function automatic logic [PFA_ADDR_W-1:0] free_target();
        logic [PFA_ADDR_W:0]   floor_addr;
        logic [PFA_ADDR_W:0]   page_span;
        logic [PFA_ADDR_W-1:0] a;
        int unsigned           pick;
        page_span  = (PFA_ADDR_W+1)'(PFA_FRAME_BYTES);
        floor_addr = {1'b0, bump_frontier()} + page_span;
        pick       = $urandom_range(99);
        if (floor_addr[PFA_ADDR_W] || pick < 10)
            a = $urandom();
        else if (pick < 18)
            a = floor_addr[PFA_ADDR_W-1:0] - PFA_ADDR_W'($urandom_range(1, 8));
        else
        begin
            a = floor_addr[PFA_ADDR_W-1:0]
                + PFA_ADDR_W'($urandom_range(0, 32'hFFFF_FFFF - floor_addr[PFA_ADDR_W-1:0]));
            // floor is page aligned, so clearing the offset keeps it at or above
            if ($urandom_range(99) < 70)
                a[PFA_PAGE_SHIFT-1:0] = '0;
        end
        return a;
    endfunction

    function automatic void row_cfg(logic [PFA_CFG_IDX_W-1:0] idx, logic [PFA_ADDR_W-1:0] data);
        script_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        script.push_back(r);
    endfunction

    // request row checked against the shadow model
    function automatic void row_req(logic act, logic [PFA_ADDR_W-1:0] addr);
        script_row_t r;
        r                  = '0;
        r.op.action        = act;
        r.op.frame_address = addr;
        script.push_back(r);
    endfunction

    // request row with the result typed in
    function automatic void row_chk(logic act, logic [PFA_ADDR_W-1:0] addr,
                                    logic [PFA_ADDR_W-1:0] grant, pfa_status_t st, int count);
        script_row_t r;
        r                      = '0;
        r.op.action            = act;
        r.op.frame_address     = addr;
        r.typed                = 1'b1;
        r.want.granted_address = grant;
        r.want.status          = st;
        r.want.free_count      = PFA_COUNT_W'(count);
        script.push_back(r);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // result checker: every strobe must match the oldest owed result
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (owed_grants.size() == 0)
                flag_mismatch($sformatf("result with nothing owed: grant %h status %0d count %0d",
                                        rsp.granted_address, rsp.status, rsp.free_count));
            else
            begin
                want = owed_grants.pop_front();
                if (rsp.granted_address !== want.granted_address)
                    flag_mismatch($sformatf("granted_address exp %h got %h",
                                            want.granted_address, rsp.granted_address));
                if (rsp.status !== want.status)
                    flag_mismatch($sformatf("status exp %0d got %0d", want.status, rsp.status));
                if (rsp.free_count !== want.free_count)
                    flag_mismatch($sformatf("free_count exp %0d got %0d",
                                            want.free_count, rsp.free_count));
            end
        end
    end

    // lower start and wait for every owed result, plus a little slack
    task automatic settle();
        start <= 1'b0;
        while (owed_grants.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // one register write transaction; valid is left high so back-to-back writes
    // need no extra nonblocking update in the same step
    task automatic write_reg(input logic [PFA_CFG_IDX_W-1:0] idx, input logic [PFA_ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
    endtask

    // one request transaction, with a random gap in front of it
    task automatic send_op(input pfa_req_t op, input int idle_pct,
                           input bit typed, input pfa_rsp_t typed_rsp);
        pfa_rsp_t predicted;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= op;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        predicted = predict_frame_op(op);
        owed_grants.push_back(typed ? typed_rsp : predicted);
    endtask

    // random phase: registers written while idle, then a stream of requests;
    // halfway through the sender holds off until the dut has drained
    task automatic run_phase(input int count, input int idle_pct, input bit paging,
                             input logic [PFA_ADDR_W-1:0] region, input int free_pct);
        pfa_req_t op;
        settle();
        write_reg(CFG_REGION_START, region);
        // upper bits of the mode write are junk the register must drop
        write_reg(CFG_PAGING_ON, ($urandom() << 1) | PFA_ADDR_W'(paging));
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                settle();
            op.action        = ($urandom_range(99) < free_pct) ? ACT_FREE : ACT_ALLOC;
            op.frame_address = (op.action == ACT_FREE) ? free_target() : $urandom();
            send_op(op, idle_pct, 1'b0, '0);
        end
    endtask

    initial
    begin
        bit settled;

        // after reset: bump base 0x1000, paging off
        row_chk(ACT_ALLOC, 32'h0000_0000, 32'h0000_1000, STAT_OK, 0);
        row_chk(ACT_ALLOC, 32'hFFFF_FFFF, 32'h0000_2000, STAT_OK, 0);
        // free in bump mode is ignored
        row_chk(ACT_FREE,  32'h0001_0000, 32'h0,         STAT_IGNORED, 0);
        row_cfg(CFG_PAGING_ON, 32'h1);
        // pop from an empty stack
        row_chk(ACT_ALLOC, 32'h0000_0000, 32'h0,         STAT_EMPTY, 0);
        // frontier 0x3000, so anything below 0x4000 is ignored
        row_chk(ACT_FREE,  32'h0000_3FFF, 32'h0,         STAT_IGNORED, 0);
        row_chk(ACT_FREE,  32'h0000_0000, 32'h0,         STAT_IGNORED, 0);
        row_chk(ACT_FREE,  32'h0000_4000, 32'h0,         STAT_OK, 1);
        row_chk(ACT_FREE,  32'hFFFF_FFFF, 32'h0,         STAT_OK, 2);
        // unaligned address goes on the stack as is
        row_req(ACT_FREE,  32'h0012_3457);
        row_chk(ACT_ALLOC, 32'h0000_0000, 32'h0012_3457, STAT_OK, 2);
        row_req(ACT_ALLOC, 32'hA5A5_5A5A);
        row_req(ACT_ALLOC, 32'h0000_0000);
        row_chk(ACT_ALLOC, 32'h0000_0000, 32'h0,         STAT_EMPTY, 0);
        // base wraps to 0 for the top start address
        row_cfg(CFG_REGION_START, 32'hFFFF_FFFF);
        row_chk(ACT_FREE,  32'h0000_0FFF, 32'h0,         STAT_IGNORED, 0);
        row_chk(ACT_FREE,  32'h0000_1000, 32'h0,         STAT_OK, 1);
        // frontier plus one page reaches 2^32: every free ignored
        row_cfg(CFG_REGION_START, 32'hFFFF_E000);
        row_chk(ACT_FREE,  32'hFFFF_FFFF, 32'h0,         STAT_IGNORED, 1);
        // back to bump mode, stack kept; second allocation wraps to 0
        row_cfg(CFG_PAGING_ON, 32'h0);
        row_chk(ACT_ALLOC, 32'h0000_0000, 32'hFFFF_F000, STAT_OK, 1);
        row_chk(ACT_ALLOC, 32'h0000_0000, 32'h0000_0000, STAT_OK, 1);
        row_req(ACT_FREE,  32'h8000_0000);
        // writes to missing registers and junk upper bits change nothing
        row_cfg(CFG_SPARE_LOW, 32'hFFFF_FFFF);
        row_cfg(CFG_SPARE_TOP, 32'hFFFF_FFFF);
        row_cfg(CFG_PAGING_ON, 32'hFFFF_FFFE);
        row_chk(ACT_ALLOC, 32'h0000_0000, 32'h0000_1000, STAT_OK, 1);
        row_cfg(CFG_PAGING_ON, 32'h0000_0003);
        row_cfg(CFG_REGION_START, 32'h0000_0000);
        row_chk(ACT_ALLOC, 32'h0000_0000, 32'h0000_1000, STAT_OK, 0);
        row_req(ACT_FREE,  32'h0000_2000);

        // everything known from time 0 while reset is held low
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req        <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        exp_region  = '0;
        exp_paging  = 1'b0;
        exp_bump    = '0;
        exp_depth   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        settled = 1'b1;
        foreach (script[k])
        begin
            if (script[k].is_cfg)
            begin
                if (!settled)
                    settle();
                write_reg(script[k].idx, script[k].data);
                settled = 1'b1;
            end
            else
            begin
                send_op(script[k].op, 0, script[k].typed, script[k].want);
                settled = 1'b0;
            end
        end

        // random phases: no gaps, sender mostly idle, fill the stack past full,
        // light gaps while it drains
        run_phase(150, 0, 1'b1, $urandom_range(0, 32'h00FF_FFFF), 55);
        run_phase(150, 81, 1'b0, $urandom(), 15);
        run_phase(1250, 0, 1'b1, $urandom_range(0, 32'h000F_FFFF), 97);
        run_phase(200, 22, 1'b1, $urandom_range(0, 32'h00FF_FFFF), 40);

        // drain and let any stray strobe show up
        start <= 1'b0;
        while (owed_grants.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && owed_grants.size() == 0)
            $display("page_frame_allocator_tb OK");
        else
            $display("page_frame_allocator_tb NOT OK");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("page_frame_allocator_tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
hdl/pfa_pkg.sv
hdl/pfa_stack_mem.sv
hdl/page_frame_allocator.sv
tb/page_frame_allocator_tb.sv
